[src/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/lbps_pkg.sv]
package lbps_pkg;

	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int WIDE_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int PAT_W   = 3;
	localparam int STEP_W  = 3;
	localparam int LEN_W   = 4;
	localparam int REG_IDX_W = 1;

	localparam logic [PAT_W-1:0] PAT_SLOW_BLINK = 3'd2;
	localparam logic [PAT_W-1:0] PAT_LAST_VALID = 3'd6;

	localparam logic [REG_IDX_W-1:0] REG_QUICK_TICKS = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_SLOW_TICKS  = 1'd1;

	localparam logic [CFG_W-1:0] QUICK_TICKS_RESET = 16'd10;
	localparam logic [CFG_W-1:0] SLOW_TICKS_RESET  = 16'd50;

	typedef struct packed {
		logic [CFG_W-1:0] quick_ticks;
		logic [CFG_W-1:0] slow_ticks;
	} cfg_t;

	typedef struct packed {
		logic             led_on;
		logic [PAT_W-1:0] pattern;
		logic             start;
	} result_t;

	typedef struct packed {
		logic slow;
		logic level;
	} rom_entry_t;

	function automatic logic [LEN_W-1:0] pat_len(input logic [PAT_W-1:0] pat);
		logic [LEN_W-1:0] len;
		case (pat)
			3'd0: len = 4'd1;
			3'd1: len = 4'd2;
			3'd2: len = 4'd2;
			3'd3: len = 4'd4;
			3'd4: len = 4'd6;
			3'd5: len = 4'd6;
			3'd6: len = 4'd8;
			default: len = 4'd2;
		endcase
		return len;
	endfunction

	// bit1 selects the slow duration, bit0 is the led level
	function automatic rom_entry_t pat_rom(input logic [PAT_W-1:0] pat,
		input logic [STEP_W-1:0] idx);
		rom_entry_t e;
		case ({pat, idx})
			{3'd0, 3'd0}: e = 2'b11;
			{3'd1, 3'd0}: e = 2'b01;
			{3'd2, 3'd0}: e = 2'b11;
			{3'd2, 3'd1}: e = 2'b10;
			{3'd3, 3'd0}: e = 2'b01;
			{3'd3, 3'd2}: e = 2'b01;
			{3'd3, 3'd3}: e = 2'b10;
			{3'd4, 3'd0}: e = 2'b01;
			{3'd4, 3'd2}: e = 2'b01;
			{3'd4, 3'd4}: e = 2'b11;
			{3'd5, 3'd0}: e = 2'b01;
			{3'd5, 3'd2}: e = 2'b01;
			{3'd5, 3'd4}: e = 2'b01;
			{3'd5, 3'd5}: e = 2'b10;
			{3'd6, 3'd0}: e = 2'b01;
			{3'd6, 3'd2}: e = 2'b01;
			{3'd6, 3'd4}: e = 2'b11;
			{3'd6, 3'd6}: e = 2'b11;
			{3'd7, 3'd0}: e = 2'b11;
			{3'd7, 3'd1}: e = 2'b10;
			default: e = 2'b00;
		endcase
		return e;
	endfunction

endpackage

[src/led_blink_pattern_sequencer.sv]
// led blink pattern sequencer
// in channel (in_valid/in_ready/requested_pattern): one transaction per timer
//   tick, carrying the pattern wanted (0..6, 7 falls back to slow blink). the
//   request is sampled only when the running pattern starts over.
// out channel (out_valid/out_ready/led_on/pattern_in_effect/pattern_start):
//   exactly one transaction per input tick, in order.
// cfg port (cfg_we/cfg_index/cfg_wdata): index 0 quick_ticks, 1 slow_ticks;
//   write only while no tick is in flight.
// path: an accepted tick is held in the input register; its result is registered
//   into the output register when that register is free or draining, and the
//   outputs show the output register's contents.
// throughput: one tick per cycle without stalls; step logic is a countdown,
//   a small pattern rom and one duration mux between input and output registers.
// stall: when out_ready is low the output holds; one more tick is taken into
//   the input register, then in_ready drops until the output drains.
// reset: slow blink selected, step counter at zero so the first tick starts a
//   pattern; quick_ticks 10, slow_ticks 50; both channels empty.
module led_blink_pattern_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lbps_pkg::PAT_W-1:0]          requested_pattern,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                led_on,
	output logic [lbps_pkg::PAT_W-1:0]          pattern_in_effect,
	output logic                                pattern_start,
	input  logic                                cfg_we,
	input  logic [lbps_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [lbps_pkg::CFG_W-1:0]          cfg_wdata
);

	logic                       valid_s1;
	logic [lbps_pkg::PAT_W-1:0] req_s1;
	logic                       move;
	lbps_pkg::cfg_t             cfg;
	lbps_pkg::result_t          res;
	lbps_pkg::result_t          res_q;
	logic                       out_valid_q;

	assign move     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move;

	lbps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lbps_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (move),
		.req     (req_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= requested_pattern;
		end
		if (move) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign led_on            = res_q.led_on;
	assign pattern_in_effect = res_q.pattern;
	assign pattern_start     = res_q.start;

endmodule

[src/lbps_cfg.sv]
module lbps_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lbps_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [lbps_pkg::CFG_W-1:0]           cfg_wdata,
	output lbps_pkg::cfg_t                       cfg
);

	lbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quick_ticks <= lbps_pkg::QUICK_TICKS_RESET;
			cfg_q.slow_ticks  <= lbps_pkg::SLOW_TICKS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lbps_pkg::REG_QUICK_TICKS: cfg_q.quick_ticks <= cfg_wdata;
				lbps_pkg::REG_SLOW_TICKS:  cfg_q.slow_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/lbps_seq.sv]
`include "assert_macros.svh"

module lbps_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [lbps_pkg::PAT_W-1:0]    req,
	input  lbps_pkg::cfg_t                cfg,
	output lbps_pkg::result_t             res
);

	logic [lbps_pkg::PAT_W-1:0]  active_q;
	logic [lbps_pkg::STEP_W-1:0] step_q;
	logic [lbps_pkg::CNT_W-1:0]  ticks_q;
	logic                        led_q;

	logic [lbps_pkg::PAT_W-1:0]  pat_nxt;
	logic [lbps_pkg::STEP_W-1:0] step_nxt;
	logic [lbps_pkg::CNT_W-1:0]  ticks_nxt;
	logic                        led_nxt;
	logic                        start;
	logic                        load;

	logic [lbps_pkg::LEN_W-1:0]  len;
	logic [lbps_pkg::STEP_W-1:0] idx;
	logic [lbps_pkg::LEN_W-1:0]  idx_inc;
	lbps_pkg::rom_entry_t        entry;
	logic [lbps_pkg::CFG_W-1:0]  dur;
	logic [lbps_pkg::CFG_W-1:0]  dur_m1;
	logic [lbps_pkg::WIDE_W-1:0] dur_wide;
	logic [lbps_pkg::CNT_W-1:0]  load_val;

	localparam logic [lbps_pkg::WIDE_W-1:0] CntMaxWide =
		lbps_pkg::WIDE_W'({lbps_pkg::CNT_W{1'b1}});

	assign load  = (ticks_q == '0);
	assign start = load && (step_q == '0);

	// request is sampled only when the pattern starts over
	always_comb begin
		pat_nxt = active_q;
		if (start) begin
			pat_nxt = (req <= lbps_pkg::PAT_LAST_VALID) ? req : lbps_pkg::PAT_SLOW_BLINK;
		end
	end

	assign len      = lbps_pkg::pat_len(pat_nxt);
	assign idx      = ({1'b0, step_q} >= len) ? '0 : step_q;
	assign entry    = lbps_pkg::pat_rom(pat_nxt, idx);
	assign idx_inc  = {1'b0, idx} + 1'b1;
	assign dur      = entry.slow ? cfg.slow_ticks : cfg.quick_ticks;
	assign dur_m1   = (dur == '0) ? '0 : dur - 1'b1;
	assign dur_wide = lbps_pkg::WIDE_W'(dur_m1);
	// saturate when the counter is narrower than the duration
	assign load_val = (dur_wide > CntMaxWide) ? {lbps_pkg::CNT_W{1'b1}}
		: lbps_pkg::CNT_W'(dur_wide);

	always_comb begin
		step_nxt  = step_q;
		ticks_nxt = ticks_q - 1'b1;
		led_nxt   = led_q;
		if (load) begin
			step_nxt  = (idx_inc >= len) ? '0 : idx_inc[lbps_pkg::STEP_W-1:0];
			ticks_nxt = load_val;
			led_nxt   = entry.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= lbps_pkg::PAT_SLOW_BLINK;
			step_q   <= '0;
			ticks_q  <= '0;
			led_q    <= 1'b0;
		end else if (advance) begin
			active_q <= pat_nxt;
			step_q   <= step_nxt;
			ticks_q  <= ticks_nxt;
			led_q    <= led_nxt;
		end
	end

	assign res.led_on  = led_nxt;
	assign res.pattern = pat_nxt;
	assign res.start   = start;

	`ASSERT_IMPLIES(a_no_invalid_pattern, clk, arst_n, 1'b1, active_q <= lbps_pkg::PAT_LAST_VALID)
	`ASSERT_IMPLIES(a_step_in_range, clk, arst_n, 1'b1,
		{1'b0, step_q} < lbps_pkg::pat_len(active_q))
	`ASSERT_NEXT(a_countdown, clk, arst_n, advance && !load,
		ticks_q == $past(ticks_q) - 1'b1 && active_q == $past(active_q))
	`ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !advance,
		$stable(ticks_q) && $stable(step_q) && $stable(active_q))

endmodule

[tb/tb_led_blink_pattern_sequencer.sv]
module tb_led_blink_pattern_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lbps_pkg::PAT_W-1:0] PAT_INVALID = 3'd7;
	localparam int TAIL_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int TIMEOUT_NS = 1_600_000;

	// per pattern: number of steps, lit steps, slow steps (bit n is step n)
	localparam logic [7:0][3:0] STEP_COUNT =
		{4'd2, 4'd8, 4'd6, 4'd6, 4'd4, 4'd2, 4'd2, 4'd1};
	localparam logic [7:0][7:0] LIT_MASK =
		{8'h01, 8'h55, 8'h15, 8'h15, 8'h05, 8'h01, 8'h01, 8'h01};
	localparam logic [7:0][7:0] SLOW_MASK =
		{8'h03, 8'h50, 8'h20, 8'h10, 8'h08, 8'h03, 8'h00, 8'h01};

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [lbps_pkg::PAT_W-1:0] requested_pattern = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic led_on;
	logic [lbps_pkg::PAT_W-1:0] pattern_in_effect;
	logic pattern_start;
	logic cfg_we = 1'b0;
	logic [lbps_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [lbps_pkg::CFG_W-1:0] cfg_wdata = '0;

	// model of the sequencer state and its registers
	lbps_pkg::cfg_t cur_cfg = '{quick_ticks: lbps_pkg::QUICK_TICKS_RESET,
		slow_ticks: lbps_pkg::SLOW_TICKS_RESET};
	logic [lbps_pkg::PAT_W-1:0] cur_pat = lbps_pkg::PAT_SLOW_BLINK;
	logic [lbps_pkg::STEP_W-1:0] step_idx = '0;
	logic [lbps_pkg::CNT_W-1:0] ticks_left = '0;
	logic led_lvl = 1'b0;

	logic [lbps_pkg::PAT_W-1:0] pending_ticks[$];
	lbps_pkg::result_t led_frames_q[$];
	lbps_pkg::result_t seen_frame;
	lbps_pkg::result_t want_frame;

	int n_pushed = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_bad = 0;
	int holds_done = 0;
	int hold_left = 0;
	int mode_left = 100;
	idle_mode_t idle_mode = IDLE_NONE;

	logic [lbps_pkg::PAT_W-1:0] opening_reqs [24] = '{
		3'd7, 3'd0, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4,
		3'd5, 3'd6, 3'd0, 3'd7, 3'd0, 3'd0, 3'd1, 3'd1,
		3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd7, 3'd0
	};

	wire [6:0] gap_pct = (idle_mode == IDLE_SENDER) ? 7'd67 :
		(idle_mode == IDLE_BOTH) ? 7'd26 : 7'd0;
	wire [6:0] stall_pct = (idle_mode == IDLE_RECEIVER) ? 7'd67 :
		(idle_mode == IDLE_BOTH) ? 7'd26 : 7'd0;

	led_blink_pattern_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.requested_pattern(requested_pattern),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_on(led_on),
		.pattern_in_effect(pattern_in_effect),
		.pattern_start(pattern_start),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// advance the sequencer by one tick and return the frame it shows
	function automatic lbps_pkg::result_t blink_step(input logic [lbps_pkg::PAT_W-1:0] req);
		lbps_pkg::result_t frame;
		logic [lbps_pkg::CFG_W-1:0] dur;
		logic [3:0] len;
		frame.start = 1'b0;
		if (ticks_left == '0) begin
			if (step_idx == '0) begin
				cur_pat = (req > lbps_pkg::PAT_LAST_VALID) ? lbps_pkg::PAT_SLOW_BLINK : req;
				frame.start = 1'b1;
			end
			len = STEP_COUNT[cur_pat];
			if ({1'b0, step_idx} >= len)
				step_idx = '0;
			led_lvl = LIT_MASK[cur_pat][step_idx];
			dur = SLOW_MASK[cur_pat][step_idx] ? cur_cfg.slow_ticks : cur_cfg.quick_ticks;
			// zero duration behaves as one tick
			if (dur == '0)
				dur = lbps_pkg::CFG_W'(1);
			ticks_left = dur - 1'b1;
			if ({1'b0, step_idx} + 4'd1 >= len)
				step_idx = '0;
			else
				step_idx = step_idx + 1'b1;
		end else begin
			ticks_left = ticks_left - 1'b1;
		end
		frame.led_on = led_lvl;
		frame.pattern = cur_pat;
		return frame;
	endfunction

	task automatic write_reg(input logic [lbps_pkg::REG_IDX_W-1:0] idx,
		input logic [lbps_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lbps_pkg::REG_QUICK_TICKS)
			cur_cfg.quick_ticks = val;
		else
			cur_cfg.slow_ticks = val;
	endtask

	// runs of one request with some noise mixed in
	task automatic queue_requests(input int count);
		logic [lbps_pkg::PAT_W-1:0] want;
		logic [lbps_pkg::PAT_W-1:0] noise;
		int run;
		while (count > 0) begin
			if ($urandom_range(9) == 0)
				want = PAT_INVALID;
			else
				want = $urandom_range(lbps_pkg::PAT_LAST_VALID);
			run = $urandom_range(1, 30);
			while (run > 0 && count > 0) begin
				noise = $urandom_range(7);
				pending_ticks.push_back(($urandom_range(9) == 0) ? noise : want);
				n_pushed++;
				run--;
				count--;
			end
		end
	endtask

	task automatic wait_drained();
		while (n_results < n_pushed)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [lbps_pkg::CFG_W-1:0] quick,
		input logic [lbps_pkg::CFG_W-1:0] slow, input int count);
		write_reg(lbps_pkg::REG_QUICK_TICKS, quick);
		write_reg(lbps_pkg::REG_SLOW_TICKS, slow);
		queue_requests(count);
		wait_drained();
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				led_frames_q.push_back(blink_step(requested_pattern));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				// no gaps while the receiver is held off, so the block backs up
				if (pending_ticks.size() != 0 &&
					(hold_left != 0 || $urandom_range(99) >= gap_pct)) begin
					in_valid <= 1'b1;
					requested_pattern <= pending_ticks.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				seen_frame.led_on = led_on;
				seen_frame.pattern = pattern_in_effect;
				seen_frame.start = pattern_start;
				if (led_frames_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected transaction: led_on %0b pattern %0d start %0b",
							seen_frame.led_on, seen_frame.pattern, seen_frame.start);
				end else begin
					want_frame = led_frames_q.pop_front();
					if (seen_frame.led_on !== want_frame.led_on ||
						seen_frame.pattern !== want_frame.pattern ||
						seen_frame.start !== want_frame.start) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"mismatch at result %0d: exp led_on %0b pattern %0d",
								" start %0b, got led_on %0b pattern %0d start %0b"},
								n_results, want_frame.led_on, want_frame.pattern,
								want_frame.start, seen_frame.led_on, seen_frame.pattern,
								seen_frame.start);
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// idle pattern changes every so often
	always @(posedge clk) begin
		if (mode_left == 0) begin
			idle_mode <= idle_mode_t'($urandom_range(3));
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
	end

	// long receiver hold-offs
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && n_accepted >= 500) ||
			(holds_done == 1 && n_accepted >= 1300)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// first tick after reset, every request value, invalid ones
		foreach (opening_reqs[i]) begin
			pending_ticks.push_back(opening_reqs[i]);
			n_pushed++;
		end
		// reset durations
		queue_requests(150);
		wait_drained();

		run_phase(16'd0, 16'd0, 250);
		run_phase(16'd1, 16'd1, 350);
		run_phase(16'd1, 16'd2, 350);
		run_phase(16'd2, 16'd7, 350);
		run_phase(16'd3, 16'd1, 250);
		run_phase(16'd4, 16'd3, 100);
		run_phase(16'd1, 16'hFFFF, 40);
		run_phase(16'hFFFF, 16'hFFFF, 40);

		if (n_bad == 0 && led_frames_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#TIMEOUT_NS;
		$display("FAILURE");
		$finish;
	end

endmodule
